/* src/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the keyed slot table
// Field widths, operation and status codes, configuration register indexes,
// reset values of the limits and the request/response word layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

    localparam int KEY_W   = 27;
    localparam int AGE_W   = 7;
    localparam int CFG_IW  = 2;
    localparam int SLOT_OW = 5;
    localparam int CNT_OW  = 6;

    localparam logic [KEY_W-1:0] KEY_MIN_RST = 27'd1000000;
    localparam logic [KEY_W-1:0] KEY_MAX_RST = 27'd99999999;
    localparam logic [AGE_W-1:0] AGE_MIN_RST = 7'd1;
    localparam logic [AGE_W-1:0] AGE_MAX_RST = 7'd100;

    typedef enum logic [CFG_IW-1:0] {
        CFG_KEY_MIN = 2'd0,
        CFG_KEY_MAX = 2'd1,
        CFG_AGE_MIN = 2'd2,
        CFG_AGE_MAX = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_COUNT  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_LIMITS    = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_mode            mode;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [AGE_W-1:0] range_low;
        logic [AGE_W-1:0] range_high;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [SLOT_OW-1:0] slot;
        logic               found;
        logic [CNT_OW-1:0]  count;
    } t_rsp;

endpackage

`default_nettype wire

/* src/kst_if.sv */
// ----------------------------------------------------------------------------
// kst_if: valid/ready channels of the keyed slot table
// Request channel carrying one operation word, response channel carrying
// one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface kst_req_if;
    logic          valid;
    logic          ready;
    kst_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kst_rsp_if;
    logic          valid;
    logic          ready;
    kst_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/keyed_slot_table_core.sv */
// ----------------------------------------------------------------------------
// keyed_slot_table_core: record table with lowest-free-slot insert
// Insert, delete, lookup and age-range count over SLOTS records, each
// examined in turn by one shared compare stage.
// ----------------------------------------------------------------------------
// Each operation word occupies the block from the cycle in which it is
// accepted: every record is read in turn through the single read port of
// the record memory, a write-back cycle follows and the result is then held
// on offer until it is taken. The next word is accepted in the cycle after
// the result has been taken. After reset the valid flags are cleared by a
// pass over every slot during which no word is accepted; configuration
// writes are taken at any time.
`default_nettype none

module keyed_slot_table_core #(
    parameter int SLOTS = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [kst_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [kst_pkg::KEY_W-1:0]  i_cfg_data,
    kst_req_if.sink                        i_req,
    kst_rsp_if.source                      o_rsp
);
    import kst_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = 1 + KEY_W + AGE_W;

    // Record memory: valid flag, key, age.
    logic [MW-1:0] r_mem [SLOTS];
    logic [MW-1:0] r_rd_data;

    t_state r_state, n_state;

    logic [KEY_W-1:0] r_key_min, r_key_max;
    logic [AGE_W-1:0] r_age_min, r_age_max;

    t_req          r_req;
    logic          r_key_ok, r_age_ok;
    logic [CW-1:0] r_cnt;
    logic          r_pend;
    logic [SW-1:0] r_chk;
    logic          r_found;
    logic [SW-1:0] r_hit_slot;
    logic          r_free_seen;
    logic [SW-1:0] r_free_slot;
    logic [CW-1:0] r_count;
    t_rsp          r_rsp;

    logic          w_accept;
    logic          w_rd_en;
    logic          w_we;
    logic [SW-1:0] w_waddr;
    logic [MW-1:0] w_wdata;
    logic          w_scan_done;
    logic          w_ins_ok;
    t_rsp          w_rsp;

    logic             w_rec_valid;
    logic [KEY_W-1:0] w_rec_key;
    logic [AGE_W-1:0] w_rec_age;
    logic             w_hit;
    logic             w_in_range;

    logic [SW+SLOT_OW-1:0] w_slot_ext;
    logic [SW-1:0]         w_slot_sel;
    logic [CW+CNT_OW-1:0]  w_count_ext;

    assign w_accept = i_req.valid && i_req.ready;

    assign w_rec_valid = r_rd_data[MW-1];
    assign w_rec_key   = r_rd_data[MW-2:AGE_W];
    assign w_rec_age   = r_rd_data[AGE_W-1:0];

    // Shared compare stage applied to the record read in the previous cycle.
    assign w_hit      = w_rec_valid && (w_rec_key == r_req.key);
    assign w_in_range = w_rec_valid && (w_rec_age >= r_req.range_low)
                        && (w_rec_age <= r_req.range_high);

    assign w_scan_done = r_pend && (r_chk == SW'(SLOTS - 1));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_min <= KEY_MIN_RST;
            r_key_max <= KEY_MAX_RST;
            r_age_min <= AGE_MIN_RST;
            r_age_max <= AGE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_MIN: r_key_min <= i_cfg_data;
                CFG_KEY_MAX: r_key_max <= i_cfg_data;
                CFG_AGE_MIN: r_age_min <= i_cfg_data[AGE_W-1:0];
                CFG_AGE_MAX: r_age_max <= i_cfg_data[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_cnt == CW'(SLOTS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (w_accept) n_state = ST_SCAN;
            ST_SCAN:  if (w_scan_done) n_state = ST_WRITE;
            ST_WRITE: n_state = ST_RESP;
            ST_RESP:  if (o_rsp.ready) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        i_req.ready = 1'b0;
        o_rsp.valid = 1'b0;
        w_rd_en     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_cnt[SW-1:0];
        w_wdata     = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_SCAN: begin
                w_rd_en = (r_cnt < CW'(SLOTS));
                // A delete clears the flag of each matching record in turn.
                if (r_pend && w_hit && r_key_ok && (r_req.mode == MODE_DELETE)) begin
                    w_we    = 1'b1;
                    w_waddr = r_chk;
                    w_wdata = {1'b0, w_rec_key, w_rec_age};
                end
            end
            ST_WRITE: begin
                if (w_ins_ok) begin
                    w_we    = 1'b1;
                    w_waddr = r_free_slot;
                    w_wdata = {1'b1, r_req.key, r_req.age};
                end
            end
            ST_RESP: begin
                o_rsp.valid = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result word
    // ------------------------------------------------------------------
    assign w_ins_ok = (r_req.mode == MODE_INSERT) && r_key_ok && r_age_ok
                      && !r_found && r_free_seen;

    always_comb begin
        w_rsp.status = STAT_OK;
        w_slot_sel   = '0;
        w_rsp.found  = r_found;
        w_count_ext  = '0;
        case (r_req.mode)
            MODE_INSERT: begin
                if (!(r_key_ok && r_age_ok)) begin
                    w_rsp.status = STAT_LIMITS;
                end else if (r_found) begin
                    w_rsp.status = STAT_DUPLICATE;
                end else if (!r_free_seen) begin
                    w_rsp.status = STAT_FULL;
                end else begin
                    w_slot_sel = r_free_slot;
                end
            end
            MODE_DELETE: begin
                if (!r_key_ok) begin
                    w_rsp.status = STAT_LIMITS;
                end else if (!r_found) begin
                    w_rsp.status = STAT_NOT_FOUND;
                end
            end
            MODE_LOOKUP: begin
                if (r_found) begin
                    w_slot_sel = r_hit_slot;
                end else begin
                    w_rsp.status = STAT_NOT_FOUND;
                end
            end
            default: begin
                w_count_ext = {{CNT_OW{1'b0}}, r_count};
            end
        endcase
        w_slot_ext  = {{SLOT_OW{1'b0}}, w_slot_sel};
        w_rsp.slot  = w_slot_ext[SLOT_OW-1:0];
        w_rsp.count = w_count_ext[CNT_OW-1:0];
    end

    assign o_rsp.data = r_rsp;

    // ------------------------------------------------------------------
    // Record memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_cnt[SW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_rd_en;
            if (r_state == ST_CLEAR || r_state == ST_SCAN) begin
                r_cnt <= (r_cnt < CW'(SLOTS)) ? r_cnt + CW'(1) : r_cnt;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Operation word, scan results and result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_chk <= r_cnt[SW-1:0];
        if (w_accept) begin
            r_req       <= i_req.data;
            r_key_ok    <= (i_req.data.key >= r_key_min) && (i_req.data.key <= r_key_max);
            r_age_ok    <= (i_req.data.age >= r_age_min) && (i_req.data.age <= r_age_max);
            r_found     <= 1'b0;
            r_hit_slot  <= '0;
            r_free_seen <= 1'b0;
            r_free_slot <= '0;
            r_count     <= '0;
        end else if (r_state == ST_SCAN && r_pend) begin
            if (w_hit && !r_found && (r_req.mode != MODE_COUNT)) begin
                r_found    <= 1'b1;
                r_hit_slot <= r_chk;
            end
            if (!w_rec_valid && !r_free_seen) begin
                r_free_seen <= 1'b1;
                r_free_slot <= r_chk;
            end
            if (w_in_range && (r_req.mode == MODE_COUNT)) begin
                r_count <= r_count + CW'(1);
            end
        end
        if (r_state == ST_WRITE) begin
            r_rsp <= w_rsp;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rsp.valid && i_req.ready))
        else $error("result offered while a new word can be accepted");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && (r_cnt == '0))
        else $error("accepted word did not start a scan from the first slot");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_RESP) |-> !w_we)
        else $error("record memory written outside clear, scan or write-back");

    // The count only holds a value once a word has been taken.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR && r_state != ST_IDLE) |-> (r_count <= CW'(SLOTS)))
        else $error("count exceeds the number of slots");

    a_insert_ok_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_req.mode == MODE_INSERT && r_rsp.status == STAT_OK)
        |-> !r_rsp.found)
        else $error("successful insert reported an existing key");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keyed_slot_table_core
// Drives insert, delete, lookup and count words through the request channel
// and predicts every response word from a private copy of the table and its
// limits. Directed cases come first, then a table fill, then random traffic
// under a series of limit settings, with random gaps on both channels.
// ----------------------------------------------------------------------------

module testbench;

    import kst_pkg::*;

    localparam int               SLOTS       = 32;
    localparam logic [KEY_W-1:0] KEY_TOP     = 27'd99999999;
    localparam int               POOL_SIZE   = 40;
    localparam int               PHASE_WORDS = 110;
    localparam int unsigned      CYCLE_LIMIT = 300000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_IW-1:0]   i_cfg_index;
    logic [KEY_W-1:0]    i_cfg_data;

    kst_req_if req_ch ();
    kst_rsp_if rsp_ch ();

    keyed_slot_table_core #(
        .SLOTS (SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #4 i_clk = ~i_clk;

    // Private copy of the table and of the limit registers.
    logic             slot_valid [SLOTS];
    logic [KEY_W-1:0] slot_key   [SLOTS];
    logic [AGE_W-1:0] slot_age   [SLOTS];
    logic [KEY_W-1:0] lim_key_min;
    logic [KEY_W-1:0] lim_key_max;
    logic [AGE_W-1:0] lim_age_min;
    logic [AGE_W-1:0] lim_age_max;

    t_rsp             table_results [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               idle_pct;
    int               fail_count;
    int unsigned      cycle_count;

    function automatic t_rsp apply_table_op(input t_req op);
        t_rsp res;
        int   hit;
        int   free_slot;
        int   n;
        logic key_ok;
        res       = '0;
        hit       = SLOTS;
        free_slot = SLOTS;
        n         = 0;
        key_ok    = (op.key >= lim_key_min) && (op.key <= lim_key_max);
        if (op.mode != MODE_COUNT) begin
            for (int s = SLOTS - 1; s >= 0; s--)
                if (slot_valid[s] && slot_key[s] == op.key) hit = s;
            res.found = (hit < SLOTS);
        end
        case (op.mode)
            MODE_INSERT: begin
                if (!key_ok || op.age < lim_age_min || op.age > lim_age_max) begin
                    res.status = STAT_LIMITS;
                end else if (res.found) begin
                    res.status = STAT_DUPLICATE;
                end else begin
                    for (int s = SLOTS - 1; s >= 0; s--)
                        if (!slot_valid[s]) free_slot = s;
                    if (free_slot == SLOTS) begin
                        res.status = STAT_FULL;
                    end else begin
                        slot_valid[free_slot] = 1'b1;
                        slot_key[free_slot]   = op.key;
                        slot_age[free_slot]   = op.age;
                        res.slot              = SLOT_OW'(free_slot);
                    end
                end
            end
            MODE_DELETE: begin
                if (!key_ok) begin
                    res.status = STAT_LIMITS;
                end else if (!res.found) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    for (int s = 0; s < SLOTS; s++)
                        if (slot_valid[s] && slot_key[s] == op.key) slot_valid[s] = 1'b0;
                end
            end
            MODE_LOOKUP: begin
                if (res.found) res.slot = SLOT_OW'(hit);
                else res.status = STAT_NOT_FOUND;
            end
            MODE_COUNT: begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot_valid[s] && slot_age[s] >= op.range_low
                            && slot_age[s] <= op.range_high) n++;
                res.count = CNT_OW'(n);
            end
        endcase
        return res;
    endfunction

    function automatic t_req make_op(input t_mode mode, input logic [KEY_W-1:0] key,
                                     input logic [AGE_W-1:0] age,
                                     input logic [AGE_W-1:0] lo, input logic [AGE_W-1:0] hi);
        t_req op;
        op.mode       = mode;
        op.key        = key;
        op.age        = age;
        op.range_low  = lo;
        op.range_high = hi;
        return op;
    endfunction

    // Mostly keys from the pool, so that inserts collide, deletes hit and
    // the table fills up; the rest is drawn from zero up to KEY_TOP.
    function automatic t_req random_op();
        t_req        op;
        int unsigned pick;
        int unsigned lo;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op.mode = MODE_INSERT;
        else if (pick < 65) op.mode = MODE_DELETE;
        else if (pick < 85) op.mode = MODE_LOOKUP;
        else                op.mode = MODE_COUNT;
        if ($urandom_range(0, 99) < 80) op.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else op.key = KEY_W'($urandom_range(0, KEY_TOP));
        if (lim_age_min <= lim_age_max && $urandom_range(0, 99) < 85)
            op.age = AGE_W'($urandom_range(lim_age_min, lim_age_max));
        else
            op.age = AGE_W'($urandom_range(0, 127));
        lo = $urandom_range(0, 127);
        op.range_low = AGE_W'(lo);
        if ($urandom_range(0, 99) < 80) op.range_high = AGE_W'($urandom_range(lo, 127));
        else op.range_high = AGE_W'($urandom_range(0, 127));
        return op;
    endfunction

    task automatic fill_key_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (lim_key_min <= lim_key_max)
                key_pool[i] = KEY_W'(lim_key_min
                              + ($urandom % (int'(lim_key_max - lim_key_min) + 1)));
            else
                key_pool[i] = KEY_W'($urandom_range(0, KEY_TOP));
        end
    endtask

    // Offers one word after a random gap and records its predicted result
    // once the block has taken it. Valid stays high until the next call or
    // until the channel is released.
    task automatic send_op(input t_req op);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= op;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        table_results.push_back(apply_table_op(op));
    endtask

    task automatic wait_until_idle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (table_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [KEY_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_KEY_MIN: lim_key_min = value;
            CFG_KEY_MAX: lim_key_max = value;
            CFG_AGE_MIN: lim_age_min = value[AGE_W-1:0];
            CFG_AGE_MAX: lim_age_max = value[AGE_W-1:0];
        endcase
    endtask

    task automatic apply_limits(input logic [KEY_W-1:0] kmin, input logic [KEY_W-1:0] kmax,
                                input logic [AGE_W-1:0] amin, input logic [AGE_W-1:0] amax);
        wait_until_idle();
        write_reg(CFG_KEY_MIN, kmin);
        write_reg(CFG_KEY_MAX, kmax);
        write_reg(CFG_AGE_MIN, KEY_W'(amin));
        write_reg(CFG_AGE_MAX, KEY_W'(amax));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Opens the key limits and deletes every record the table holds.
    task automatic flush_table();
        logic [KEY_W-1:0] held [$];
        for (int s = 0; s < SLOTS; s++)
            if (slot_valid[s]) held.push_back(slot_key[s]);
        apply_limits(0, KEY_TOP, lim_age_min, lim_age_max);
        foreach (held[i]) send_op(make_op(MODE_DELETE, held[i], 0, 0, 0));
    endtask

    task automatic run_phase(input logic [KEY_W-1:0] kmin, input logic [KEY_W-1:0] kmax,
                             input logic [AGE_W-1:0] amin, input logic [AGE_W-1:0] amax,
                             input bit flush);
        if (flush) flush_table();
        apply_limits(kmin, kmax, amin, amax);
        fill_key_pool();
        repeat (PHASE_WORDS) send_op(random_op());
    endtask

    task automatic test_directed_ops();
        send_op(make_op(MODE_COUNT,  0, 0, 0, 127));
        send_op(make_op(MODE_LOOKUP, KEY_MIN_RST, 0, 0, 0));
        send_op(make_op(MODE_DELETE, KEY_MIN_RST, 0, 0, 0));
        send_op(make_op(MODE_INSERT, KEY_MIN_RST - KEY_W'(1), 50, 0, 0));
        send_op(make_op(MODE_INSERT, 0, 50, 0, 0));
        send_op(make_op(MODE_INSERT, KEY_MIN_RST, AGE_MIN_RST, 0, 0));
        send_op(make_op(MODE_INSERT, KEY_MAX_RST, AGE_MAX_RST, 0, 0));
        send_op(make_op(MODE_INSERT, KEY_MIN_RST, 5, 0, 0));
        // Limits are checked before the duplicate test.
        send_op(make_op(MODE_INSERT, KEY_MIN_RST, 0, 0, 0));
        send_op(make_op(MODE_INSERT, 5000000, 0, 0, 0));
        send_op(make_op(MODE_INSERT, 5000000, AGE_MAX_RST + AGE_W'(1), 0, 0));
        send_op(make_op(MODE_INSERT, 5000000, 127, 0, 0));
        send_op(make_op(MODE_LOOKUP, KEY_MAX_RST, 0, 0, 0));
        send_op(make_op(MODE_COUNT,  0, 0, 1, 1));
        send_op(make_op(MODE_COUNT,  0, 0, 100, 0));
        send_op(make_op(MODE_DELETE, KEY_MIN_RST, 0, 0, 0));
        send_op(make_op(MODE_INSERT, 2000000, 60, 0, 0));
        send_op(make_op(MODE_DELETE, 0, 0, 0, 0));
        // Lookup ignores the key limits.
        send_op(make_op(MODE_LOOKUP, 0, 0, 0, 0));
        send_op(make_op(MODE_COUNT,  0, 0, 0, 127));
        send_op(make_op(MODE_COUNT,  0, 0, 127, 127));
    endtask

    // Distinct keys fill every free slot, then further inserts find the
    // table full; freed slots are then reused lowest first.
    task automatic test_fill_table();
        logic [KEY_W-1:0] fill_keys [34];
        for (int i = 0; i < 34; i++)
            fill_keys[i] = KEY_W'(3000000 + i * 2000000 + $urandom_range(0, 1999999));
        foreach (fill_keys[i])
            send_op(make_op(MODE_INSERT, fill_keys[i], AGE_W'($urandom_range(1, 100)), 0, 0));
        send_op(make_op(MODE_COUNT,  0, 0, 0, 127));
        send_op(make_op(MODE_LOOKUP, fill_keys[29], 0, 0, 0));
        send_op(make_op(MODE_DELETE, fill_keys[20], 0, 0, 0));
        send_op(make_op(MODE_DELETE, fill_keys[3], 0, 0, 0));
        send_op(make_op(MODE_INSERT, fill_keys[33], 77, 0, 0));
        send_op(make_op(MODE_INSERT, fill_keys[32], 1, 0, 0));
        send_op(make_op(MODE_INSERT, fill_keys[31], 2, 0, 0));
        send_op(make_op(MODE_LOOKUP, fill_keys[33], 0, 0, 0));
    endtask

    task automatic test_limit_settings();
        logic [KEY_W-1:0] kmin;
        logic [AGE_W-1:0] amin;
        run_phase(0, KEY_TOP, 0, 127, 1'b0);
        run_phase(50000000, 50000000, 64, 64, 1'b1);
        // Empty key window, then empty age window.
        run_phase(KEY_TOP, 0, 1, 100, 1'b0);
        run_phase(KEY_MIN_RST, KEY_MAX_RST, 100, 1, 1'b0);
        run_phase(67108864, KEY_TOP, 0, 127, 1'b1);
        kmin = KEY_W'($urandom_range(0, KEY_TOP));
        amin = AGE_W'($urandom_range(0, 127));
        run_phase(kmin, KEY_W'($urandom_range(kmin, KEY_TOP)),
                  amin, AGE_W'($urandom_range(amin, 127)), 1'b0);
        run_phase(KEY_MIN_RST, KEY_MAX_RST, AGE_MIN_RST, AGE_MAX_RST, 1'b1);
    endtask

    task automatic test_random_traffic();
        fill_key_pool();
        repeat (100) send_op(random_op());
        idle_pct = 0;
        repeat (100) send_op(random_op());
        idle_pct = 28;
        repeat (50) send_op(random_op());
    endtask

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (table_results.size() == 0) begin
                $error("unexpected response word: status %0d slot %0d found %0d count %0d",
                       got.status, got.slot, got.found, got.count);
                fail_count++;
            end else begin
                want = table_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                    fail_count++;
                end
                if (got.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    fail_count++;
                end
                if (got.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, got.count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_KEY_MIN;
        i_cfg_data   = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        idle_pct     = 28;
        fail_count   = 0;
        cycle_count  = 0;
        lim_key_min  = KEY_MIN_RST;
        lim_key_max  = KEY_MAX_RST;
        lim_age_min  = AGE_MIN_RST;
        lim_age_max  = AGE_MAX_RST;
        for (int s = 0; s < SLOTS; s++) begin
            slot_valid[s] = 1'b0;
            slot_key[s]   = '0;
            slot_age[s]   = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_fill_table();
        test_limit_settings();
        test_random_traffic();

        wait_until_idle();
        repeat (SLOTS + 4) @(posedge i_clk);
        if (fail_count == 0 && table_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
